@@ design/assert_macros.svh @@
// assertion macros shared by the winding tester rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define PIPW_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PIPW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/pipw_pkg.sv @@
// package with shared constants and types of the winding tester
`default_nettype none
package pipw_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COORD_WIDTH  = 16;
  localparam int VIDX_W           = 6;
  localparam int CFG_W            = 7;
  localparam int WCOUNT_W         = 8;
  localparam int QUEUE_DEPTH      = 4;

  localparam logic [CFG_W-1:0] VCOUNT_RST = 7'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } edge_ctl_t;

  typedef struct packed {
    logic done;
    logic inc;
    logic dec;
  } edge_res_t;

endpackage
`default_nettype wire

@@ design/pipw_front.sv @@
// input side: accepts items and queues them for the back end
`default_nettype none
module pipw_front #(
  parameter int COORD_WIDTH = pipw_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic                            in_cmd,
  input  wire logic [pipw_pkg::VIDX_W-1:0]     in_idx,
  input  wire logic signed [COORD_WIDTH-1:0]   in_x,
  input  wire logic signed [COORD_WIDTH-1:0]   in_y,
  output logic                                 q_valid,
  input  wire logic                            q_ready,
  output logic                                 q_cmd,
  output logic [pipw_pkg::VIDX_W-1:0]          q_idx,
  output logic signed [COORD_WIDTH-1:0]        q_x,
  output logic signed [COORD_WIDTH-1:0]        q_y
);
  import pipw_pkg::*;

  localparam int ITEM_W = 1 + VIDX_W + 2 * COORD_WIDTH;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  logic [ITEM_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;
  logic [ITEM_W-1:0] head;

  assign in_tready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_valid && q_ready;

  assign head  = entry_r[rd_ptr_r];
  assign q_cmd = head[ITEM_W-1];
  assign q_idx = head[ITEM_W-2 -: VIDX_W];
  assign q_x   = $signed(head[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign q_y   = $signed(head[COORD_WIDTH-1:0]);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= {in_cmd, in_idx, in_x, in_y};
    end
  end

`include "assert_macros.svh"
  `PIPW_ASSERT(a_cnt_range, cnt_r <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `PIPW_ASSERT_IMP(a_ptr_match, (cnt_r == '0) || (cnt_r == CNT_W'(QUEUE_DEPTH)), wr_ptr_r == rd_ptr_r, "queue pointers disagree with count")

endmodule
`default_nettype wire

@@ design/pipw_edge.sv @@
// edge unit: exact cross product and crossing test, one edge per cycle
`default_nettype none
module pipw_edge #(
  parameter int COORD_WIDTH = pipw_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pipw_pkg::edge_ctl_t           ctl,
  input  wire logic signed [COORD_WIDTH-1:0] vx,
  input  wire logic signed [COORD_WIDTH-1:0] vy,
  input  wire logic signed [COORD_WIDTH-1:0] rx,
  input  wire logic signed [COORD_WIDTH-1:0] ry,
  output pipw_pkg::edge_res_t                res
);
  import pipw_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic signed [DW-1:0]          a_nxt, b_nxt, c_nxt, d_nxt;
  logic signed [DW-1:0]          a_r, b_r, c_r, d_r;
  logic                          va_r, la_r, upa_r, dna_r;
  logic signed [PW-1:0]          p1_r, p2_r;
  logic                          vb_r, lb_r, upb_r, dnb_r;
  logic signed [PW:0]            cross_v;
  logic                          up_nxt, dn_nxt;

  // p is the previous vertex, v the one just read, r the point
  assign a_nxt  = {vy[COORD_WIDTH-1], vy} - {py_r[COORD_WIDTH-1], py_r};
  assign b_nxt  = {rx[COORD_WIDTH-1], rx} - {vx[COORD_WIDTH-1], vx};
  assign c_nxt  = {vx[COORD_WIDTH-1], vx} - {px_r[COORD_WIDTH-1], px_r};
  assign d_nxt  = {ry[COORD_WIDTH-1], ry} - {vy[COORD_WIDTH-1], vy};
  assign up_nxt = (py_r <= ry) && (vy > ry);
  assign dn_nxt = (py_r > ry) && (vy <= ry);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      la_r <= 1'b0;
      vb_r <= 1'b0;
      lb_r <= 1'b0;
    end else begin
      va_r <= ctl.valid && !ctl.first;
      la_r <= ctl.valid && ctl.last;
      vb_r <= va_r;
      lb_r <= la_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      px_r <= vx;
      py_r <= vy;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    upa_r <= up_nxt;
    dna_r <= dn_nxt;
    p1_r  <= a_r * b_r;
    p2_r  <= c_r * d_r;
    upb_r <= upa_r;
    dnb_r <= dna_r;
  end

  assign cross_v  = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
  assign res.done = lb_r;
  assign res.inc  = vb_r && upb_r && !cross_v[PW] && (cross_v != '0);
  assign res.dec  = vb_r && dnb_r && cross_v[PW];

endmodule
`default_nettype wire

@@ design/pipw_back.sv @@
// back end: vertex store, edge walk sequencer, winding sum and result register
`default_nettype none
module pipw_back #(
  parameter int MAX_VERTICES = pipw_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = pipw_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [pipw_pkg::CFG_W-1:0]    vertex_count,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire logic                          q_cmd,
  input  wire logic [pipw_pkg::VIDX_W-1:0]   q_idx,
  input  wire logic signed [COORD_WIDTH-1:0] q_x,
  input  wire logic signed [COORD_WIDTH-1:0] q_y,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic                               out_inside,
  output logic [pipw_pkg::WCOUNT_W-1:0]      out_count
);
  import pipw_pkg::*;

  localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int IW     = ((ADDR_W > VIDX_W) ? ADDR_W : VIDX_W) + 1;
  localparam int WIND_W = (CNT_W + 1 > WCOUNT_W) ? CNT_W + 1 : WCOUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [2*COORD_WIDTH-1:0] mem [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] rd_data_r;

  logic [1:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              n_r, n_nxt;
  logic [CNT_W-1:0]              k_r, k_nxt;
  logic [WIND_W-1:0]             wind_r, wind_nxt;
  logic signed [COORD_WIDTH-1:0] rx_r, ry_r;
  edge_ctl_t                     ctl_r, ctl_nxt;
  edge_res_t                     res;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_inside_r;
  logic [WCOUNT_W-1:0]           out_count_r;

  logic [CW-1:0]     cnt_ext, n_sat;
  logic [IW-1:0]     idx_ext;
  logic              slot_ok, wr_en, rd_en, start, finish;
  logic [ADDR_W-1:0] rd_addr;

  assign cnt_ext = CW'(vertex_count);
  assign n_sat   = (cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : cnt_ext;
  assign idx_ext = IW'(q_idx);
  assign slot_ok = idx_ext < IW'(MAX_VERTICES);

  assign q_ready = (state_r == ST_IDLE);
  assign wr_en   = q_ready && q_valid && (q_cmd == CMD_LOAD) && slot_ok;
  assign start   = q_ready && q_valid && (q_cmd == CMD_TEST);
  assign rd_en   = (state_r == ST_WALK);
  assign rd_addr = (k_r == n_r) ? '0 : k_r[ADDR_W-1:0];
  assign finish  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    wind_nxt      = wind_r + WIND_W'(res.inc) - WIND_W'(res.dec);
    ctl_nxt.valid = rd_en;
    ctl_nxt.first = (k_r == '0);
    ctl_nxt.last  = (k_r == n_r);
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt     = n_sat[CNT_W-1:0];
          k_nxt     = '0;
          wind_nxt  = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        k_nxt = k_r + 1'b1;
        if (k_r == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    wind_r <= wind_nxt;
    if (start) begin
      rx_r <= q_x;
      ry_r <= q_y;
    end
    if (finish) begin
      out_inside_r <= (wind_r != '0);
      out_count_r  <= wind_r[WCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_ext[ADDR_W-1:0]] <= {q_x, q_y};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  pipw_edge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl_r),
    .vx   ($signed(rd_data_r[2*COORD_WIDTH-1:COORD_WIDTH])),
    .vy   ($signed(rd_data_r[COORD_WIDTH-1:0])),
    .rx   (rx_r),
    .ry   (ry_r),
    .res  (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_inside = out_inside_r;
  assign out_count  = out_count_r;

`include "assert_macros.svh"
  `PIPW_ASSERT_IMP(a_walk_bound, state_r == ST_WALK, k_r <= n_r, "edge walk ran past vertex count")
  `PIPW_ASSERT_IMP(a_done_drain, res.done, state_r == ST_DRAIN, "walk end seen outside drain")

endmodule
`default_nettype wire

@@ design/point_in_polygon_winding.sv @@
// Top level of the winding-number point-in-polygon tester.
// A load item passes the input queue and is written once the sequencer is idle, one load per cycle while no test runs.
// A test item walks every edge of the stored polygon: vertices are read, passed through the edge pipeline and summed.
// No new item is taken until a test's result is registered: one vertex read per cycle, then the edge pipeline drains.
// Reset clears the queue, sequencer and result valid flag and sets vertex_count to 3.
// The vertex store is not cleared; a vertex must be loaded before a test reads it.
`default_nettype none
module point_in_polygon_winding #(
  parameter int MAX_VERTICES = pipw_pkg::DEF_MAX_VERTICES,
  parameter int COORD_WIDTH  = pipw_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // cfg_wr_data: vertex_count
  input  wire logic                                cfg_wr_en,
  input  wire logic [pipw_pkg::CFG_W-1:0]          cfg_wr_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // in_tdata: vertex_index, coord_x, coord_y, zero fill
  input  wire logic [((pipw_pkg::VIDX_W + 2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: command
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // out_tdata: winding_count
  output logic [pipw_pkg::WCOUNT_W-1:0]            out_tdata,
  // out_tuser: inside_res
  output logic                                     out_tuser
);
  import pipw_pkg::*;

  logic [CFG_W-1:0]              vcount_r;
  logic                          q_valid, q_ready, q_cmd;
  logic [VIDX_W-1:0]             q_idx;
  logic signed [COORD_WIDTH-1:0] q_x, q_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
    end else if (cfg_wr_en) begin
      vcount_r <= cfg_wr_data;
    end
  end

  pipw_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_cmd   (in_tuser),
    .in_idx   (in_tdata[VIDX_W-1:0]),
    .in_x     ($signed(in_tdata[VIDX_W+COORD_WIDTH-1:VIDX_W])),
    .in_y     ($signed(in_tdata[VIDX_W+2*COORD_WIDTH-1:VIDX_W+COORD_WIDTH])),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .q_idx    (q_idx),
    .q_x      (q_x),
    .q_y      (q_y)
  );

  pipw_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .vertex_count(vcount_r),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd),
    .q_idx       (q_idx),
    .q_x         (q_x),
    .q_y         (q_y),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_inside  (out_tuser),
    .out_count   (out_tdata)
  );

endmodule
`default_nettype wire
